### hdl/four_quadrant_arctangent_assert.svh
// ----------------------------------------------------------------------------
// four_quadrant_arctangent_assert
// Assertion macros for the four-quadrant arctangent block.
// Both sample on clk_i and are disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef FOUR_QUADRANT_ARCTANGENT_ASSERT_SVH
`define FOUR_QUADRANT_ARCTANGENT_ASSERT_SVH

// Same-cycle implication.
`define FQA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fqa assertion failed");

// Consequent checked a fixed number of cycles after the antecedent.
`define FQA_ASSERT_AFTER(lbl, ante, dly, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##(dly) (cons)) \
    else $error("fqa assertion failed");

`endif

### hdl/fqa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqa_pkg
// Widths, constants and beat types shared by the arctangent pipeline.
// ----------------------------------------------------------------------------
package fqa_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int QUO_BITS    = 17;          // ratio in unsigned Q1.16
  localparam int DIV_CELLS   = QUO_BITS;    // one quotient bit per cell
  localparam int POLY_STAGES = 5;
  localparam int FQA_LATENCY = DIV_CELLS + POLY_STAGES;
  localparam int ANGLE_BITS  = 16;

  // Constants in units of 2^-30
  localparam logic [30:0] K_SUM  = 31'd1136446374;  // pi/4 + 0.273
  localparam logic [28:0] K_LIN  = 29'd293131518;   // 0.273
  localparam logic [31:0] K_HALF = 32'd1686629713;  // pi/2
  localparam logic [31:0] K_PI   = 32'd3373259426;  // pi

  typedef struct packed {
    logic xneg;
    logic yneg;
    logic ymore;
    logic zero;
  } fqa_oct_t;

  typedef struct packed {
    logic [SAMPLE_BITS:0]   part;   // partial remainder, below twice the divisor
    logic [SAMPLE_BITS-1:0] denom;  // divisor
    logic [QUO_BITS-1:0]    quo;    // quotient bits so far
    fqa_oct_t               oct;
  } fqa_div_t;

endpackage

### hdl/fqa_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqa_div_cell
// One restoring-division cell: resolves one quotient bit per beat.
// ----------------------------------------------------------------------------
module fqa_div_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  fqa_pkg::fqa_div_t data_i,
  output logic              valid_o,
  output fqa_pkg::fqa_div_t data_o
);
  import fqa_pkg::*;

  logic [SAMPLE_BITS:0] divisor;
  logic [SAMPLE_BITS:0] diff;
  logic [SAMPLE_BITS:0] rem;
  logic                 ge;
  fqa_div_t             data_d;
  fqa_div_t             data_q;
  logic                 valid_q;

  always_comb begin
    divisor = {1'b0, data_i.denom};
    diff    = data_i.part - divisor;
    ge      = data_i.part >= divisor;
    rem     = ge ? diff : data_i.part;
    data_d       = data_i;
    // remainder is below the divisor, so the shift cannot overflow
    data_d.part  = {rem[SAMPLE_BITS-1:0], 1'b0};
    data_d.quo   = {data_i.quo[QUO_BITS-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### hdl/fqa_poly.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqa_poly
// Polynomial arctangent of the ratio, octant fold and rounding to Q2.13.
// ----------------------------------------------------------------------------
module fqa_poly (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  logic [fqa_pkg::QUO_BITS-1:0]        r_i,
  input  fqa_pkg::fqa_oct_t                   oct_i,
  output logic                                valid_o,
  output logic signed [fqa_pkg::ANGLE_BITS-1:0] angle_o
);
  import fqa_pkg::*;

  localparam logic [46:0] K_SUM_Q16 = {K_SUM, 16'd0};
  localparam logic signed [34:0] BIAS    = 35'sd65536;
  localparam logic signed [34:0] HALF_S  = $signed({3'b000, K_HALF});
  localparam logic signed [34:0] PI_S    = $signed({3'b000, K_PI});

  logic [POLY_STAGES-1:0] valid_q;

  // stage 1
  logic [45:0]         lin_q;
  logic [QUO_BITS-1:0] r1_q;
  fqa_oct_t            oct1_q;
  // stage 2
  logic [46:0]         slope_d;
  logic [46:0]         slope_q;
  logic [QUO_BITS-1:0] r2_q;
  fqa_oct_t            oct2_q;
  // stage 3
  logic [40:0]         plo_q;
  logic [39:0]         phi_q;
  fqa_oct_t            oct3_q;
  // stage 4
  logic [63:0]         prod_d;
  logic [29:0]         a_q;
  fqa_oct_t            oct4_q;
  // stage 5
  logic signed [34:0]  base;
  logic                sub_a;
  logic signed [34:0]  a_s;
  logic signed [34:0]  sum_d;
  logic signed [ANGLE_BITS-1:0] angle_d;
  logic signed [ANGLE_BITS-1:0] angle_q;

  assign slope_d = K_SUM_Q16 - {1'b0, lin_q};
  assign prod_d  = ({24'd0, phi_q} << 24) + {23'd0, plo_q};
  assign a_s     = $signed({5'd0, a_q});

  always_comb begin
    base  = BIAS;
    sub_a = 1'b0;
    case ({oct4_q.xneg, oct4_q.yneg, oct4_q.ymore})
      3'b000: begin base = BIAS;          sub_a = 1'b0; end
      3'b001: begin base = BIAS + HALF_S; sub_a = 1'b1; end
      3'b010: begin base = BIAS;          sub_a = 1'b1; end
      3'b011: begin base = BIAS - HALF_S; sub_a = 1'b0; end
      3'b100: begin base = BIAS + PI_S;   sub_a = 1'b1; end
      3'b101: begin base = BIAS + HALF_S; sub_a = 1'b0; end
      3'b110: begin base = BIAS - PI_S;   sub_a = 1'b0; end
      3'b111: begin base = BIAS - HALF_S; sub_a = 1'b1; end
      default: begin base = BIAS;         sub_a = 1'b0; end
    endcase
    sum_d = sub_a ? (base - a_s) : (base + a_s);
    // arithmetic shift by 17 keeps the floor; the rounding bias is in base
    angle_d = oct4_q.zero ? '0 : sum_d[32:17];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[POLY_STAGES-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    lin_q   <= 46'(K_LIN) * 46'(r_i);
    r1_q    <= r_i;
    oct1_q  <= oct_i;
    slope_q <= slope_d;
    r2_q    <= r1_q;
    oct2_q  <= oct1_q;
    plo_q   <= 41'(slope_q[23:0]) * 41'(r2_q);
    phi_q   <= 40'(slope_q[46:24]) * 40'(r2_q);
    oct3_q  <= oct2_q;
    a_q     <= prod_d[61:32];
    oct4_q  <= oct3_q;
    angle_q <= angle_d;
  end

  assign valid_o = valid_q[POLY_STAGES-1];
  assign angle_o = angle_q;

endmodule

### hdl/four_quadrant_arctangent.sv
// Each accepted pair passes the division cells, then the polynomial stages.
// Throughput: one x/y pair per cycle; busy is held low, no stall ever.
// The pipeline is a row of 17 restoring-division cells (one quotient
// bit each) followed by five multiply and rounding stages.
// Reset (rst_ni low, asynchronous) clears every valid bit; results in flight
// are dropped and done_o stays low until new pairs reach the end.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_quadrant_arctangent
// Pipelined atan2(y, x) in signed Q2.13 radians via polynomial approximation.
// ----------------------------------------------------------------------------
`include "four_quadrant_arctangent_assert.svh"

module four_quadrant_arctangent (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     start,
  output logic                                     busy,
  input  logic signed [fqa_pkg::SAMPLE_BITS-1:0]   x_value_i,
  input  logic signed [fqa_pkg::SAMPLE_BITS-1:0]   y_value_i,
  output logic                                     done_o,
  output logic signed [fqa_pkg::ANGLE_BITS-1:0]    angle_o
);
  import fqa_pkg::*;

  logic [SAMPLE_BITS-1:0] x_raw;
  logic [SAMPLE_BITS-1:0] y_raw;
  logic [SAMPLE_BITS-1:0] mag_x;
  logic [SAMPLE_BITS-1:0] mag_y;
  logic [SAMPLE_BITS-1:0] small_mag;
  logic [SAMPLE_BITS-1:0] large_mag;
  logic                   ymore;
  logic                   accept;
  logic                   zero_in;

  logic [DIV_CELLS:0]     div_valid;
  fqa_div_t               div_data [DIV_CELLS+1];

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign zero_in = accept && x_value_i == '0 && y_value_i == '0;

  always_comb begin
    x_raw = x_value_i;
    y_raw = y_value_i;
    // -2^(N-1) maps to 2^(N-1), which still fits unsigned
    mag_x = x_raw[SAMPLE_BITS-1] ? (-x_raw) : x_raw;
    mag_y = y_raw[SAMPLE_BITS-1] ? (-y_raw) : y_raw;
    ymore = mag_x <= mag_y;
    small_mag = ymore ? mag_x : mag_y;
    large_mag = ymore ? mag_y : mag_x;

    div_valid[0]          = accept;
    div_data[0].part      = {1'b0, small_mag};
    div_data[0].denom     = large_mag;
    div_data[0].quo       = '0;
    div_data[0].oct.xneg  = x_raw[SAMPLE_BITS-1];
    div_data[0].oct.yneg  = y_raw[SAMPLE_BITS-1];
    div_data[0].oct.ymore = ymore;
    div_data[0].oct.zero  = (large_mag == '0);
  end

  for (genvar g = 0; g < DIV_CELLS; g++) begin : g_cell
    fqa_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (div_valid[g]),
      .data_i  (div_data[g]),
      .valid_o (div_valid[g+1]),
      .data_o  (div_data[g+1])
    );
  end

  fqa_poly u_poly (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (div_valid[DIV_CELLS]),
    .r_i     (div_data[DIV_CELLS].quo),
    .oct_i   (div_data[DIV_CELLS].oct),
    .valid_o (done_o),
    .angle_o (angle_o)
  );

  `FQA_ASSERT_AFTER(a_latency, accept, FQA_LATENCY, done_o)
  `FQA_ASSERT_AFTER(a_zero_in, zero_in, FQA_LATENCY, angle_o == '0)
  `FQA_ASSERT_NOW(a_range, done_o, angle_o >= -16'sd25736 && angle_o <= 16'sd25736)

endmodule

### sim/four_quadrant_arctangent_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_quadrant_arctangent_test
// Self-checking bench for the pipelined arctangent. A short table covers the
// axes, diagonals, zero and full-scale samples, then about 400 random x/y
// pairs follow in bursts with idle gaps. Every done_o beat is compared with
// the oldest expected angle, from the table or a fixed-point prediction.
// ----------------------------------------------------------------------------
module four_quadrant_arctangent_test;

  localparam int SB = fqa_pkg::SAMPLE_BITS;
  localparam int AB = fqa_pkg::ANGLE_BITS;
  localparam int RANDOM_PAIRS = 400;
  localparam int LIMIT_CYCLES = 100000;
  localparam int SETTLE_CYCLES = fqa_pkg::FQA_LATENCY + 10;

  // Angle constants in units of 2^-30
  localparam logic [63:0] ATAN_SLOPE0 = 64'd1136446374;  // pi/4 + 0.273
  localparam logic [63:0] ATAN_CURVE  = 64'd293131518;   // 0.273
  localparam longint      RIGHT_ANGLE = 64'sd1686629713; // pi/2
  localparam longint      STRAIGHT    = 64'sd3373259426; // pi

  localparam int CORNER_VALS [6] = '{-32768, -32767, -1, 0, 1, 32767};

  typedef struct {
    int  x;
    int  y;
    bit  known;
    int  angle;
  } pair_row_t;

  localparam int DIR_ROWS = 25;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic signed [SB-1:0] x_value_i;
  logic signed [SB-1:0] y_value_i;
  logic                 done_o;
  logic signed [AB-1:0] angle_o;

  logic signed [AB-1:0] angles_due [$];
  pair_row_t            dir_rows [DIR_ROWS];
  int                   mismatches = 0;
  int                   cycle_count = 0;
  int                   burst_left = 0;

  four_quadrant_arctangent DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .x_value_i (x_value_i),
    .y_value_i (y_value_i),
    .done_o    (done_o),
    .angle_o   (angle_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Octant fold, truncated ratio, polynomial, then round to Q2.13.
  function automatic logic signed [AB-1:0] atan2_q13(input logic signed [SB-1:0] x,
                                                      input logic signed [SB-1:0] y);
    logic [SB:0]  mag_x;
    logic [SB:0]  mag_y;
    logic [SB:0]  lesser;
    logic [SB:0]  greater;
    logic         y_major;
    logic [63:0]  ratio;
    logic [63:0]  slope;
    longint       arc;
    longint       turned;
    longint       rounded;
    mag_x = x[SB-1] ? ({1'b1, {SB{1'b0}}} - {1'b0, x}) : {1'b0, x};
    mag_y = y[SB-1] ? ({1'b1, {SB{1'b0}}} - {1'b0, y}) : {1'b0, y};
    y_major = (mag_x <= mag_y);
    lesser  = y_major ? mag_x : mag_y;
    greater = y_major ? mag_y : mag_x;
    if (greater == '0) begin
      return '0;
    end
    ratio = (64'(lesser) << 16) / 64'(greater);
    slope = ATAN_SLOPE0 * 64'd65536 - ATAN_CURVE * ratio;
    arc   = longint'((slope * ratio) >> 32);
    case ({x[SB-1], y[SB-1]})
      2'b00:   turned = y_major ? (RIGHT_ANGLE - arc) : arc;
      2'b01:   turned = y_major ? (arc - RIGHT_ANGLE) : -arc;
      2'b10:   turned = y_major ? (RIGHT_ANGLE + arc) : (STRAIGHT - arc);
      default: turned = y_major ? (-RIGHT_ANGLE - arc) : (arc - STRAIGHT);
    endcase
    rounded = (turned + 64'sd65536) >>> 17;
    return rounded[AB-1:0];
  endfunction

  // Hold the pair on the bus until it is taken, then log what it must produce.
  task automatic issue_pair(input logic signed [SB-1:0] x, input logic signed [SB-1:0] y,
                            input bit known, input logic signed [AB-1:0] typed_angle);
    start     <= 1'b1;
    x_value_i <= x;
    y_value_i <= y;
    do @(posedge clk_i); while (busy);
    angles_due.push_back(known ? typed_angle : atan2_q13(x, y));
  endtask

  // Close a burst now and then with an idle gap of random length.
  task automatic pace();
    int unsigned gap;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        start     <= 1'b0;
        x_value_i <= SB'($urandom);
        y_value_i <= SB'($urandom);
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic pick_pair(output logic signed [SB-1:0] x, output logic signed [SB-1:0] y);
    int kind;
    int a;
    int b;
    int t;
    kind = $urandom_range(0, 9);
    a = int'($urandom_range(0, 65535)) - 32768;
    case (kind)
      4: begin
        a = int'($urandom_range(0, 8)) - 4;
        b = int'($urandom_range(0, 8)) - 4;
      end
      5: b = ($urandom_range(0, 1) ? a : -a) + int'($urandom_range(0, 6)) - 3;
      6: b = 0;
      7: begin
        a = CORNER_VALS[$urandom_range(0, 5)];
        b = CORNER_VALS[$urandom_range(0, 5)];
      end
      8: b = int'($urandom_range(0, 64)) - 32;
      9: b = $urandom_range(0, 1) ? a : -a;
      default: b = int'($urandom_range(0, 65535)) - 32768;
    endcase
    if (b > 32767) b = 32767;
    if (b < -32768) b = -32768;
    if ($urandom_range(0, 1)) begin
      t = a;
      a = b;
      b = t;
    end
    x = a[SB-1:0];
    y = b[SB-1:0];
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (angles_due.size() == 0) begin
        $error("angle: unexpected beat, actual %0d", angle_o);
        mismatches++;
      end else begin
        if (angle_o !== angles_due[0]) begin
          $error("angle: expected %0d, actual %0d", angles_due[0], angle_o);
          mismatches++;
        end
        void'(angles_due.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    logic signed [SB-1:0] rx;
    logic signed [SB-1:0] ry;
    dir_rows = '{
      '{0, 0, 1, 0},             '{1, 0, 1, 0},           '{0, 1, 1, 12868},
      '{-1, 0, 1, 25736},        '{0, -1, 1, -12868},     '{1, 1, 1, 6434},
      '{-1, 1, 1, 19302},        '{-1, -1, 1, -19302},    '{1, -1, 1, -6434},
      '{32767, 0, 1, 0},         '{-32768, 0, 1, 25736},  '{0, -32768, 1, -12868},
      '{0, 32767, 1, 12868},     '{-32768, -32768, 1, -19302},
      '{32767, 32767, 1, 6434},  '{32767, -32768, 0, 0},  '{-32768, 32767, 0, 0},
      '{32767, 1, 0, 0},         '{1, 32767, 0, 0},       '{-32768, 1, 0, 0},
      '{-32768, -32767, 0, 0},   '{-32767, -32768, 0, 0}, '{12345, -23456, 0, 0},
      '{-30000, 20000, 0, 0},    '{2, -3, 0, 0}
    };
    rst_ni    = 1'b0;
    start     = 1'b0;
    x_value_i = '0;
    y_value_i = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      issue_pair(dir_rows[i].x[SB-1:0], dir_rows[i].y[SB-1:0], dir_rows[i].known,
                 dir_rows[i].angle[AB-1:0]);
      pace();
    end

    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      // Drain the pipe once mid-run before the next beat.
      if (n == RANDOM_PAIRS / 2) begin
        start <= 1'b0;
        while (angles_due.size() != 0) @(posedge clk_i);
        @(posedge clk_i);
      end
      pick_pair(rx, ry);
      issue_pair(rx, ry, 1'b0, '0);
      pace();
    end

    start <= 1'b0;
    while (angles_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
